// ===== src/olst_pkg.sv =====
// Shared constants for the ordered list engine: sizes, opcodes and status codes.
// No dependencies.
package olst_pkg;

  localparam int CAPACITY = 64;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int HANDLE_W = 32;
  localparam int POS_W    = 6;
  localparam int OP_W     = 4;
  localparam int STAT_W   = 2;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_PUSH_F  = 4'd0;
  localparam logic [OP_W-1:0] OP_PUSH_B  = 4'd1;
  localparam logic [OP_W-1:0] OP_INSERT  = 4'd2;
  localparam logic [OP_W-1:0] OP_POP_F   = 4'd3;
  localparam logic [OP_W-1:0] OP_POP_B   = 4'd4;
  localparam logic [OP_W-1:0] OP_REMOVE  = 4'd5;
  localparam logic [OP_W-1:0] OP_PEEK_F  = 4'd6;
  localparam logic [OP_W-1:0] OP_PEEK_B  = 4'd7;
  localparam logic [OP_W-1:0] OP_PEEK_AT = 4'd8;

  // Result status
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

endpackage

// ===== src/olst_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module olst_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ordered_list_engine_top.sv =====
// Ordered list engine: doubly linked list of handles kept in slot RAMs.
// Rejects and unused opcodes go straight to the finish state; other requests read the slot RAMs
// and then execute, and push back or insert onto a nonempty list adds a link step. Indexed requests
// first walk the next-link RAM chain, up to 63 positions. A held result stalls the finish state.
// One request at a time; the next is taken once the result is in the output register.
// Reset (synchronous, rst_n low): list empty, all slots free, no result pending.
// Depends on olst_pkg and olst_ram.
module ordered_list_engine_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [olst_pkg::OP_W-1:0]     in_opcode,
  input  logic [olst_pkg::HANDLE_W-1:0] in_handle_in,
  input  logic [olst_pkg::POS_W-1:0]    in_position,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [olst_pkg::STAT_W-1:0]   out_status,
  output logic [olst_pkg::HANDLE_W-1:0] out_handle_out,
  output logic [olst_pkg::CNT_W-1:0]    out_count_now,
  output logic                          out_is_empty
);

  localparam int SW = olst_pkg::SLOT_W;
  localparam int CW = olst_pkg::CNT_W;
  localparam int HW = olst_pkg::HANDLE_W;
  localparam int CAP_N = olst_pkg::CAPACITY;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_WALKW = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_EXE   = 3'd4;
  localparam logic [2:0] S_LNK   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]                  state_r;
  logic [olst_pkg::OP_W-1:0]   op_r;
  logic [HW-1:0]               h_r;
  logic [olst_pkg::POS_W-1:0]  cnt_r;
  logic [SW-1:0]               cur_r, front_r, back_r, s_r, nx_r;
  logic [CW-1:0]               count_r;
  logic [olst_pkg::STAT_W-1:0] stat_r;
  logic [HW-1:0]               hout_r;
  logic [CAP_N-1:0]            fvld_r;
  logic                        fvld_q;

  // RAM ports
  logic          h_we, n_we, p_we, f_we;
  logic [SW-1:0] h_wa, n_wa, p_wa, f_wa, n_wd, p_wd, f_wd, f_ra;
  logic [HW-1:0] h_q;
  logic [SW-1:0] n_q, p_q, f_mem_q, free_q;

  olst_ram #(.DEPTH(CAP_N), .WIDTH(HW)) u_hdl (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_r), .raddr(cur_r), .rdata(h_q));
  olst_ram #(.DEPTH(CAP_N), .WIDTH(SW)) u_nxt (
    .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(cur_r), .rdata(n_q));
  olst_ram #(.DEPTH(CAP_N), .WIDTH(SW)) u_prv (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(cur_r), .rdata(p_q));
  olst_ram #(.DEPTH(CAP_N), .WIDTH(SW)) u_free (
    .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_mem_q));

  // Free stack top; an entry never written since reset reads as the count itself
  assign f_ra   = SW'(CAP_N - 1) - count_r[SW-1:0];
  assign free_q = fvld_q ? f_mem_q : count_r[SW-1:0];

  logic is_push, is_unlink, is_peek;
  assign is_push   = (op_r == olst_pkg::OP_PUSH_F) || (op_r == olst_pkg::OP_PUSH_B) ||
                     (op_r == olst_pkg::OP_INSERT);
  assign is_unlink = (op_r == olst_pkg::OP_POP_F) || (op_r == olst_pkg::OP_POP_B) ||
                     (op_r == olst_pkg::OP_REMOVE);
  assign is_peek   = (op_r == olst_pkg::OP_PEEK_F) || (op_r == olst_pkg::OP_PEEK_B) ||
                     (op_r == olst_pkg::OP_PEEK_AT);

  logic [CW-1:0] cnt_dec;
  assign cnt_dec = count_r - CW'(1);

  // Write ports per step
  always_comb begin
    h_we = 1'b0; h_wa = free_q;
    n_we = 1'b0; n_wa = free_q; n_wd = n_q;
    p_we = 1'b0; p_wa = free_q; p_wd = cur_r;
    f_we = 1'b0; f_wa = SW'(CAP_N - 1) - cnt_dec[SW-1:0]; f_wd = cur_r;
    if (state_r == S_EXE && is_push) begin
      h_we = 1'b1;
      if (count_r != '0) begin
        n_we = 1'b1;
        p_we = 1'b1;
        if (op_r == olst_pkg::OP_PUSH_F) begin
          n_wd = front_r;
          p_wa = front_r;
          p_wd = free_q;
        end
      end
    end else if (state_r == S_EXE && is_unlink) begin
      f_we = 1'b1;
      n_we = (cur_r != front_r);
      n_wa = p_q;
      n_wd = n_q;
      p_we = (cur_r != back_r);
      p_wa = n_q;
      p_wd = p_q;
    end else if (state_r == S_LNK) begin
      n_we = 1'b1;
      n_wa = cur_r;
      n_wd = s_r;
      p_we = (cur_r != back_r);
      p_wa = nx_r;
      p_wd = s_r;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // Request checks at transfer
  logic [olst_pkg::STAT_W-1:0] chk_stat;
  logic                        bad_pos, is_full, is_emp, op_known, op_indexed;
  assign bad_pos    = {1'b0, in_position} >= count_r;
  assign is_full    = count_r >= CW'(CAP_N);
  assign is_emp     = count_r == '0;
  assign op_known   = in_opcode <= olst_pkg::OP_PEEK_AT;
  assign op_indexed = (in_opcode == olst_pkg::OP_INSERT) || (in_opcode == olst_pkg::OP_REMOVE) ||
                      (in_opcode == olst_pkg::OP_PEEK_AT);

  always_comb begin
    chk_stat = olst_pkg::ST_OK;
    case (in_opcode)
      olst_pkg::OP_PUSH_F, olst_pkg::OP_PUSH_B: begin
        if (is_full) chk_stat = olst_pkg::ST_FULL;
      end
      olst_pkg::OP_INSERT: begin
        if (bad_pos) chk_stat = olst_pkg::ST_RANGE;
        else if (is_full) chk_stat = olst_pkg::ST_FULL;
      end
      olst_pkg::OP_POP_F, olst_pkg::OP_POP_B, olst_pkg::OP_PEEK_F, olst_pkg::OP_PEEK_B: begin
        if (is_emp) chk_stat = olst_pkg::ST_EMPTY;
      end
      olst_pkg::OP_REMOVE, olst_pkg::OP_PEEK_AT: begin
        if (bad_pos) chk_stat = olst_pkg::ST_RANGE;
      end
      default: chk_stat = olst_pkg::ST_OK;
    endcase
  end

  // Sequencer and list registers
  always_ff @(posedge clk) begin
    fvld_q <= fvld_r[f_ra];
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      front_r   <= '0;
      back_r    <= '0;
      fvld_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state_r == S_FIN && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (f_we) fvld_r[f_wa] <= 1'b1;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r   <= in_opcode;
            h_r    <= in_handle_in;
            cnt_r  <= in_position;
            stat_r <= chk_stat;
            hout_r <= '0;
            if ((in_opcode == olst_pkg::OP_PUSH_B) || (in_opcode == olst_pkg::OP_POP_B) ||
                (in_opcode == olst_pkg::OP_PEEK_B)) cur_r <= back_r;
            else cur_r <= front_r;
            if (!op_known || chk_stat != olst_pkg::ST_OK) state_r <= S_FIN;
            else if (op_indexed) state_r <= S_WALK;
            else state_r <= S_RD;
          end
        end
        S_WALK: begin
          if (cnt_r == '0) state_r <= S_RD;
          else state_r <= S_WALKW;
        end
        S_WALKW: begin
          cur_r   <= n_q;
          cnt_r   <= cnt_r - olst_pkg::POS_W'(1);
          state_r <= S_WALK;
        end
        S_RD: state_r <= S_EXE;
        S_EXE: begin
          state_r <= S_FIN;
          if (is_push) begin
            if (count_r == '0) begin
              front_r <= free_q;
              back_r  <= free_q;
              count_r <= count_r + CW'(1);
            end else if (op_r == olst_pkg::OP_PUSH_F) begin
              front_r <= free_q;
              count_r <= count_r + CW'(1);
            end else begin
              s_r     <= free_q;
              nx_r    <= n_q;
              state_r <= S_LNK;
            end
          end else if (is_unlink) begin
            hout_r  <= h_q;
            count_r <= cnt_dec;
            if (cnt_dec == '0) begin
              front_r <= '0;
              back_r  <= '0;
            end else begin
              if (cur_r == front_r) front_r <= n_q;
              if (cur_r == back_r) back_r <= p_q;
            end
          end else if (is_peek) begin
            hout_r <= h_q;
          end
        end
        S_LNK: begin
          if (cur_r == back_r) back_r <= s_r;
          count_r <= count_r + CW'(1);
          state_r <= S_FIN;
        end
        S_FIN: begin
          // result moves into the output register
          if (!out_valid || !out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (state_r == S_FIN && (!out_valid || !out_stall)) begin
      out_status     <= stat_r;
      out_handle_out <= hout_r;
      out_count_now  <= count_r;
      out_is_empty   <= (count_r == '0);
    end
  end

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAP_N)) else $error("entry count beyond capacity");
  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (front_r == '0 && back_r == '0)) else $error("empty list keeps ends");
  a_bad_hout: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != olst_pkg::ST_OK) |-> (out_handle_out == '0))
    else $error("handle on rejected request");
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_count_now == '0))) else $error("empty flag mismatch");

endmodule

// ===== bench/tb_ordered_list_engine_top.sv =====
// Testbench for ordered_list_engine_top: directed and random list requests with a
// behavioral list predictor, random idling on both channels and a full-block stall test.
// Depends on olst_pkg and the engine RTL.
module tb_ordered_list_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [olst_pkg::STAT_W-1:0]   status;
    logic [olst_pkg::HANDLE_W-1:0] handle;
    logic [olst_pkg::CNT_W-1:0]    count;
    logic                          empty;
  } list_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [olst_pkg::OP_W-1:0]     in_opcode = '0;
  logic [olst_pkg::HANDLE_W-1:0] in_handle_in = '0;
  logic [olst_pkg::POS_W-1:0]    in_position = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [olst_pkg::STAT_W-1:0]   out_status;
  logic [olst_pkg::HANDLE_W-1:0] out_handle_out;
  logic [olst_pkg::CNT_W-1:0]    out_count_now;
  logic                          out_is_empty;

  ordered_list_engine_top dut (.*);

  // Predictor state: list contents front to back
  logic [olst_pkg::HANDLE_W-1:0] list_q[$];
  list_result_t        expected_q[$];
  int  errors = 0;
  int  sent = 0;
  int  got = 0;
  bit  calm = 1'b0;      // no idling on either side
  bit  hold_rx = 1'b0;   // receiver held off by its own process
  int  hold_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Work out the result of one request and update the list copy
  function automatic list_result_t predict_list(logic [olst_pkg::OP_W-1:0] op,
                                                logic [olst_pkg::HANDLE_W-1:0] h,
                                                logic [olst_pkg::POS_W-1:0] pos);
    list_result_t r;
    int n;
    n = list_q.size();
    r.status = olst_pkg::ST_OK;
    r.handle = '0;
    case (op)
      olst_pkg::OP_PUSH_F, olst_pkg::OP_PUSH_B: begin
        if (n >= olst_pkg::CAPACITY) r.status = olst_pkg::ST_FULL;
        else if (op == olst_pkg::OP_PUSH_F) list_q.push_front(h);
        else list_q.push_back(h);
      end
      olst_pkg::OP_INSERT: begin
        if (pos >= n) r.status = olst_pkg::ST_RANGE;
        else if (n >= olst_pkg::CAPACITY) r.status = olst_pkg::ST_FULL;
        else list_q.insert(pos + 1, h);
      end
      olst_pkg::OP_POP_F, olst_pkg::OP_POP_B: begin
        if (n == 0) r.status = olst_pkg::ST_EMPTY;
        else if (op == olst_pkg::OP_POP_F) r.handle = list_q.pop_front();
        else r.handle = list_q.pop_back();
      end
      olst_pkg::OP_REMOVE: begin
        if (pos >= n) r.status = olst_pkg::ST_RANGE;
        else begin
          r.handle = list_q[pos];
          list_q.delete(pos);
        end
      end
      olst_pkg::OP_PEEK_F, olst_pkg::OP_PEEK_B: begin
        if (n == 0) r.status = olst_pkg::ST_EMPTY;
        else r.handle = (op == olst_pkg::OP_PEEK_F) ? list_q[0] : list_q[n-1];
      end
      olst_pkg::OP_PEEK_AT: begin
        if (pos >= n) r.status = olst_pkg::ST_RANGE;
        else r.handle = list_q[pos];
      end
      default: ;
    endcase
    r.count = olst_pkg::CNT_W'(list_q.size());
    r.empty = (list_q.size() == 0);
    return r;
  endfunction

  // Send one request; prediction made at the transfer edge
  task automatic send_request(logic [olst_pkg::OP_W-1:0] op,
                              logic [olst_pkg::HANDLE_W-1:0] h,
                              logic [olst_pkg::POS_W-1:0] pos);
    while (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_handle_in <= h;
    in_position  <= pos;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_list(op, h, pos));
    sent++;
  endtask

  // Receiver stall: random idling, or a long hold-off
  always @(posedge clk) begin
    if (hold_rx) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else out_stall <= !calm && ($urandom_range(99) < 21);
  end

  // Result checker
  always @(posedge clk) begin
    list_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      got++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status=%0d handle=%h", $time, out_status,
                 out_handle_out);
      end else begin
        e = expected_q.pop_front();
        if (out_status !== e.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
        end
        if (out_handle_out !== e.handle) begin
          errors++;
          $display("%0t: handle expected %h actual %h", $time, e.handle, out_handle_out);
        end
        if (out_count_now !== e.count) begin
          errors++;
          $display("%0t: count expected %0d actual %0d", $time, e.count, out_count_now);
        end
        if (out_is_empty !== e.empty) begin
          errors++;
          $display("%0t: empty expected %0b actual %0b", $time, e.empty, out_is_empty);
        end
      end
    end
  end

  // Stop offering and wait for every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Empty-list cases, extremes of fields, unused opcodes
  task automatic test_directed();
    send_request(olst_pkg::OP_POP_F, '0, '0);
    send_request(olst_pkg::OP_POP_B, '0, '0);
    send_request(olst_pkg::OP_PEEK_F, '0, '0);
    send_request(olst_pkg::OP_PEEK_B, '0, '0);
    send_request(olst_pkg::OP_PEEK_AT, '0, '0);
    send_request(olst_pkg::OP_REMOVE, '0, '0);
    send_request(olst_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd63);
    send_request(olst_pkg::OP_PUSH_B, 32'hFFFF_FFFF, 6'd63);
    send_request(olst_pkg::OP_PUSH_F, 32'h0000_0000, 6'd0);
    send_request(olst_pkg::OP_INSERT, 32'hA5A5_5A5A, 6'd0);
    send_request(olst_pkg::OP_INSERT, 32'h1234_5678, 6'd2);
    send_request(olst_pkg::OP_PEEK_AT, '0, 6'd1);
    send_request(olst_pkg::OP_PEEK_AT, '0, 6'd3);
    send_request(olst_pkg::OP_PEEK_F, '0, '0);
    send_request(olst_pkg::OP_PEEK_B, '0, '0);
    send_request(olst_pkg::OP_REMOVE, '0, 6'd1);
    send_request(4'd9, 32'hDEAD_BEEF, 6'd5);
    send_request(4'd15, 32'hFFFF_FFFF, 6'd63);
    send_request(olst_pkg::OP_POP_B, '0, '0);
    send_request(olst_pkg::OP_POP_F, '0, '0);
    send_request(olst_pkg::OP_POP_F, '0, '0);
    send_request(olst_pkg::OP_POP_F, '0, '0);
    wait_drained();
  endtask

  // Fill to capacity with the receiver held off, then full rejects, a peek, a removal and an insert at the end
  task automatic test_fill_and_hold();
    hold_rx = 1'b1;
    hold_cycles = 0;
    fork
      begin
        while (hold_cycles < 400) @(posedge clk);
        hold_rx = 1'b0;
      end
    join_none
    while (list_q.size() < olst_pkg::CAPACITY)
      send_request(olst_pkg::OP_PUSH_B, $urandom, '0);
    send_request(olst_pkg::OP_PUSH_F, $urandom, '0);
    send_request(olst_pkg::OP_INSERT, $urandom, 6'd63);
    send_request(olst_pkg::OP_PEEK_AT, '0, 6'd63);
    send_request(olst_pkg::OP_REMOVE, '0, 6'd63);
    send_request(olst_pkg::OP_INSERT, $urandom, 6'd62);
    wait_drained();
    wait fork;
    // drain to empty from both ends
    while (list_q.size() > 0)
      send_request($urandom_range(1) ? olst_pkg::OP_POP_F : olst_pkg::OP_POP_B, '0, '0);
    wait_drained();
  endtask

  // Random requests, mostly valid positions, with pushes biased to keep the list busy
  task automatic test_random(int items);
    int k, n, r;
    logic [olst_pkg::OP_W-1:0] op;
    logic [olst_pkg::POS_W-1:0] pos;
    for (k = 0; k < items; k++) begin
      calm = (k >= items / 3) && (k < items / 3 + 80);
      n = list_q.size();
      r = $urandom_range(99);
      if (r < 4) op = olst_pkg::OP_W'($urandom_range(15));
      else if (r < 45) op = olst_pkg::OP_W'($urandom_range(2));
      else op = olst_pkg::OP_W'($urandom_range(3, 8));
      // small positions are common; deep walks only sometimes
      if (n > 0 && $urandom_range(9) < 8)
        pos = ($urandom_range(3) == 0) ? olst_pkg::POS_W'(n - 1) :
                                         olst_pkg::POS_W'($urandom_range(n - 1) % 16);
      else pos = olst_pkg::POS_W'($urandom);
      if (pos >= n && n > 0 && $urandom_range(1)) pos = olst_pkg::POS_W'($urandom_range(n - 1));
      send_request(op, $urandom, pos);
    end
    calm = 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_fill_and_hold();
    test_random(700);
    repeat (300) @(posedge clk);
    $display("Covered %0d requests (%0d results): empty, full and range rejects,", sent, got);
    $display("indexed walks to the last position, and a long output hold-off.");
    if (errors == 0 && expected_q.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

// ===== ordered_list_engine_top.f =====
src/olst_pkg.sv
src/olst_ram.sv
src/ordered_list_engine_top.sv
bench/tb_ordered_list_engine_top.sv
